FILE: design/gtbs_pkg.sv
`timescale 1ns / 1ps
package gtbs_pkg;

  localparam int MAX_TILES = 1024;
  localparam int MAX_BINS  = 64;
  localparam int WORK_BITS = 24;
  localparam int SUM_BITS  = 34;
  localparam int CFG_BITS  = 7;
  localparam int IDX_BITS  = 12;
  localparam int OP_BITS   = 2;

  localparam int TILE_BITS = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_BITS  = $clog2(MAX_TILES + 1);
  localparam int BIN_BITS  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NB_BITS   = $clog2(MAX_BINS + 1);
  localparam int SEC_BITS  = IDX_BITS + 1;

  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;

  localparam logic [CFG_BITS-1:0] BIN_COUNT_RESET = 7'd8;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [WORK_BITS-1:0] tile_work;
    logic [IDX_BITS-1:0]  word_index;
  } in_word_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] word;
    logic                out_of_range;
  } out_word_t;

  // one tile in the sorting chain
  typedef struct packed {
    logic                 valid;
    logic [WORK_BITS-1:0] work;
    logic [TILE_BITS-1:0] tile;
  } tile_ent_t;

  // one bin in the load-ordered chain
  typedef struct packed {
    logic                valid;
    logic [SUM_BITS-1:0] load;
    logic [BIN_BITS-1:0] bin;
    logic [CNT_BITS-1:0] count;
  } bin_ent_t;

  typedef struct packed {
    logic      clear;
    logic      insert;
    logic      rotate;
    tile_ent_t ins;
  } sort_ctl_t;

  typedef struct packed {
    logic                init;
    logic                step;
    logic                shift;
    logic [CNT_BITS-1:0] used;
    bin_ent_t            key;
  } bin_ctl_t;

  typedef struct packed {
    logic [BIN_BITS-1:0]  bin;
    logic [TILE_BITS-1:0] tile;
  } rank_t;

endpackage

FILE: design/greedy_tile_bin_scheduler.sv
`timescale 1ns / 1ps
// Greedy tile-to-bin scheduler. Append tile work counts (one per cycle while idle), then
// read schedule words: bin end counts, tile indices grouped by bin, work prefix sums.
// A read passes through an address state and an output state, and waits in the
// latter while the output is stalled. The first read after an append, clear or
// bin_count write rebuilds the schedule: one full rotation of the tile sorting
// chain, the bin chain unload, and the per-tile placement walk through the count
// memory.
module greedy_tile_bin_scheduler import gtbs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_word,
  input  logic                cfg_write,
  input  logic [CFG_BITS-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_SORT    = 4'd2;
  localparam logic [3:0] S_DUMP    = 4'd3;
  localparam logic [3:0] S_CUM_RD  = 4'd4;
  localparam logic [3:0] S_CUM_WR  = 4'd5;
  localparam logic [3:0] S_PL_RD   = 4'd6;
  localparam logic [3:0] S_PL_FILL = 4'd7;
  localparam logic [3:0] S_PL_WR   = 4'd8;
  localparam logic [3:0] S_RD_ADDR = 4'd9;
  localparam logic [3:0] S_RD_OUT  = 4'd10;

  localparam logic [1:0] SEL_END  = 2'd0;
  localparam logic [1:0] SEL_ORD  = 2'd1;
  localparam logic [1:0] SEL_PRE  = 2'd2;
  localparam logic [1:0] SEL_NONE = 2'd3;

  logic [3:0]           state;
  logic [CFG_BITS-1:0]  bin_count;
  logic [CNT_BITS-1:0]  tile_total;
  logic [SUM_BITS-1:0]  acc;
  logic                 schedule_ready;
  logic [IDX_BITS-1:0]  rd_idx;
  logic [1:0]           rd_sel;
  logic [CNT_BITS-1:0]  r;
  logic [NB_BITS-1:0]   k;
  logic [CNT_BITS-1:0]  cum;

  logic [NB_BITS-1:0]   nb;
  logic [CNT_BITS-1:0]  used;
  logic                 in_acc;
  logic                 out_free;

  sort_ctl_t            sctl;
  bin_ctl_t             bctl;
  tile_ent_t            tcell [MAX_TILES];
  logic                 tahead [MAX_TILES];
  bin_ent_t             bcell [MAX_BINS];
  logic                 blt [MAX_BINS];

  logic                 cnt_we, cnt_re;
  logic [BIN_BITS-1:0]  cnt_waddr, cnt_raddr;
  logic [CNT_BITS-1:0]  cnt_wdata, cnt_rdata;
  logic                 rank_we, rank_re;
  rank_t                rank_wdata, rank_rdata;
  logic                 end_we, end_re;
  logic [BIN_BITS-1:0]  end_raddr;
  logic [CNT_BITS-1:0]  end_rdata;
  logic                 ord_we, ord_re;
  logic [TILE_BITS-1:0] ord_raddr;
  logic [TILE_BITS-1:0] ord_rdata;
  logic                 pre_we, pre_re;
  logic [TILE_BITS-1:0] pre_raddr;
  logic [SUM_BITS-1:0]  pre_rdata, pre_wdata;

  logic [CNT_BITS-1:0]  size;
  logic [SEC_BITS-1:0]  lim1, lim2, lim3, idx_ext, off_ord, off_pre;

  assign nb = (bin_count == '0) ? NB_BITS'(1) :
              (bin_count > CFG_BITS'(MAX_BINS)) ? NB_BITS'(MAX_BINS) :
              NB_BITS'(bin_count);
  assign used = (tile_total < CNT_BITS'(nb)) ? tile_total : CNT_BITS'(nb);

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign pre_wdata = acc + SUM_BITS'(in_word.tile_work);

  // tile sorting chain
  always_comb begin
    sctl.clear      = in_acc && (in_word.op == OP_CLEAR);
    sctl.insert     = in_acc && (in_word.op == OP_APPEND) &&
                      (tile_total < CNT_BITS'(MAX_TILES));
    sctl.rotate     = (state == S_SORT);
    sctl.ins.valid  = 1'b1;
    sctl.ins.work   = in_word.tile_work;
    sctl.ins.tile   = tile_total[TILE_BITS-1:0];
  end

  for (genvar g = 0; g < MAX_TILES; g++) begin : g_tile
    gtbs_sort_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (sctl),
      .prev       ((g == 0) ? tile_ent_t'('0) : tcell[(g == 0) ? 0 : g - 1]),
      .prev_ahead ((g == 0) ? 1'b0 : tahead[(g == 0) ? 0 : g - 1]),
      .next       (tcell[(g + 1) % MAX_TILES]),
      .cur        (tcell[g]),
      .ahead      (tahead[g])
    );
  end

  // bin chain, kept in (load, bin) order with the least-loaded bin at the head
  always_comb begin
    bctl.init       = (state == S_INIT);
    bctl.step       = (state == S_SORT) && (r < tile_total);
    bctl.shift      = (state == S_DUMP);
    bctl.used       = used;
    bctl.key.valid  = 1'b1;
    bctl.key.load   = bcell[0].load + SUM_BITS'(tcell[0].work);
    bctl.key.bin    = bcell[0].bin;
    bctl.key.count  = bcell[0].count + CNT_BITS'(1);
  end

  for (genvar g = 0; g < MAX_BINS; g++) begin : g_bin
    gtbs_bin_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (bctl),
      .pos     (BIN_BITS'(g)),
      .next    ((g == MAX_BINS - 1) ? bin_ent_t'('0) :
                bcell[(g == MAX_BINS - 1) ? g : g + 1]),
      .next_lt ((g == MAX_BINS - 1) ? 1'b0 : blt[(g == MAX_BINS - 1) ? g : g + 1]),
      .cur     (bcell[g]),
      .lt      (blt[g])
    );
  end

  // per-bin count, then fill position
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = bcell[0].bin;
    cnt_wdata = bcell[0].count;
    unique case (state)
      S_DUMP: begin
        cnt_we = bcell[0].valid;
      end
      S_CUM_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = k[BIN_BITS-1:0];
        cnt_wdata = cum;
      end
      S_PL_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = rank_rdata.bin;
        cnt_wdata = cnt_rdata + CNT_BITS'(1);
      end
      default: ;
    endcase
    cnt_re    = (state == S_CUM_RD) || (state == S_PL_FILL);
    cnt_raddr = (state == S_PL_FILL) ? rank_rdata.bin : k[BIN_BITS-1:0];
  end

  assign size = (CNT_BITS'(k) < used) ? cnt_rdata : '0;

  assign rank_we         = bctl.step;
  assign rank_wdata.bin  = bcell[0].bin;
  assign rank_wdata.tile = tcell[0].tile;
  assign rank_re         = (state == S_PL_RD);

  assign end_we = (state == S_CUM_WR);
  assign ord_we = (state == S_PL_WR);
  assign pre_we = sctl.insert;

  // read address decode
  assign idx_ext = SEC_BITS'(rd_idx);
  assign lim1    = SEC_BITS'(nb);
  assign lim2    = lim1 + SEC_BITS'(tile_total);
  assign lim3    = lim2 + SEC_BITS'(tile_total);
  assign off_ord = idx_ext - lim1;
  assign off_pre = idx_ext - lim2;

  assign end_re    = (state == S_RD_ADDR) && (idx_ext < lim1);
  assign ord_re    = (state == S_RD_ADDR) && (idx_ext >= lim1) && (idx_ext < lim2);
  assign pre_re    = (state == S_RD_ADDR) && (idx_ext >= lim2) && (idx_ext < lim3);
  assign end_raddr = rd_idx[BIN_BITS-1:0];
  assign ord_raddr = off_ord[TILE_BITS-1:0];
  assign pre_raddr = off_pre[TILE_BITS-1:0];

  gtbs_ram #(.WIDTH(CNT_BITS), .DEPTH(MAX_BINS)) u_cnt_ram (
    .clk (clk), .we (cnt_we), .waddr (cnt_waddr), .wdata (cnt_wdata),
    .re (cnt_re), .raddr (cnt_raddr), .rdata (cnt_rdata)
  );

  gtbs_ram #(.WIDTH($bits(rank_t)), .DEPTH(MAX_TILES)) u_rank_ram (
    .clk (clk), .we (rank_we), .waddr (r[TILE_BITS-1:0]), .wdata (rank_wdata),
    .re (rank_re), .raddr (r[TILE_BITS-1:0]), .rdata (rank_rdata)
  );

  gtbs_ram #(.WIDTH(CNT_BITS), .DEPTH(MAX_BINS)) u_end_ram (
    .clk (clk), .we (end_we), .waddr (k[BIN_BITS-1:0]), .wdata (cum + size),
    .re (end_re), .raddr (end_raddr), .rdata (end_rdata)
  );

  gtbs_ram #(.WIDTH(TILE_BITS), .DEPTH(MAX_TILES)) u_ord_ram (
    .clk (clk), .we (ord_we), .waddr (cnt_rdata[TILE_BITS-1:0]),
    .wdata (rank_rdata.tile), .re (ord_re), .raddr (ord_raddr), .rdata (ord_rdata)
  );

  gtbs_ram #(.WIDTH(SUM_BITS), .DEPTH(MAX_TILES)) u_pre_ram (
    .clk (clk), .we (pre_we), .waddr (tile_total[TILE_BITS-1:0]), .wdata (pre_wdata),
    .re (pre_re), .raddr (pre_raddr), .rdata (pre_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bin_count      <= BIN_COUNT_RESET;
      tile_total     <= '0;
      acc            <= '0;
      schedule_ready <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        bin_count      <= cfg_data;
        schedule_ready <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            priority case (in_word.op)
              OP_CLEAR: begin
                tile_total     <= '0;
                acc            <= '0;
                schedule_ready <= 1'b0;
              end
              OP_APPEND: begin
                if (sctl.insert) begin
                  tile_total <= tile_total + CNT_BITS'(1);
                  acc        <= pre_wdata;
                end
                schedule_ready <= 1'b0;
              end
              OP_READ: begin
                rd_idx <= in_word.word_index;
                state  <= schedule_ready ? S_RD_ADDR : S_INIT;
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          r     <= '0;
          state <= S_SORT;
        end
        S_SORT: begin
          // full rotation brings the tile chain back to its sorted state
          r <= r + CNT_BITS'(1);
          if (r == CNT_BITS'(MAX_TILES - 1)) begin
            k     <= '0;
            state <= S_DUMP;
          end
        end
        S_DUMP: begin
          k <= k + NB_BITS'(1);
          if (k == NB_BITS'(MAX_BINS - 1)) begin
            k     <= '0;
            cum   <= '0;
            state <= S_CUM_RD;
          end
        end
        S_CUM_RD: begin
          state <= S_CUM_WR;
        end
        S_CUM_WR: begin
          cum <= cum + size;
          k   <= k + NB_BITS'(1);
          if (k == nb - NB_BITS'(1)) begin
            r <= '0;
            if (tile_total == '0) begin
              schedule_ready <= 1'b1;
              state          <= S_RD_ADDR;
            end else begin
              state <= S_PL_RD;
            end
          end else begin
            state <= S_CUM_RD;
          end
        end
        S_PL_RD: begin
          state <= S_PL_FILL;
        end
        S_PL_FILL: begin
          state <= S_PL_WR;
        end
        S_PL_WR: begin
          r <= r + CNT_BITS'(1);
          if (r == tile_total - CNT_BITS'(1)) begin
            schedule_ready <= 1'b1;
            state          <= S_RD_ADDR;
          end else begin
            state <= S_PL_RD;
          end
        end
        S_RD_ADDR: begin
          if (idx_ext < lim1) begin
            rd_sel <= SEL_END;
          end else if (idx_ext < lim2) begin
            rd_sel <= SEL_ORD;
          end else if (idx_ext < lim3) begin
            rd_sel <= SEL_PRE;
          end else begin
            rd_sel <= SEL_NONE;
          end
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == S_RD_OUT) && out_free) begin
      unique case (rd_sel)
        SEL_END:  out_word <= '{word: SUM_BITS'(end_rdata), out_of_range: 1'b0};
        SEL_ORD:  out_word <= '{word: SUM_BITS'(ord_rdata), out_of_range: 1'b0};
        SEL_PRE:  out_word <= '{word: pre_rdata, out_of_range: 1'b0};
        SEL_NONE: out_word <= '{word: '0, out_of_range: 1'b1};
        default:  out_word <= '{word: '0, out_of_range: 1'b1};
      endcase
    end
  end

endmodule

FILE: design/gtbs_ram.sv
`timescale 1ns / 1ps
module gtbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/gtbs_sort_cell.sv
`timescale 1ns / 1ps
module gtbs_sort_cell import gtbs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sort_ctl_t ctl,
  input  tile_ent_t prev,
  input  logic      prev_ahead,
  input  tile_ent_t next,
  output tile_ent_t cur,
  output logic      ahead
);

  // a new tile has the highest index so far, so equal work puts it first
  assign ahead = !cur.valid || (ctl.ins.work >= cur.work);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (ctl.clear) begin
      cur.valid <= 1'b0;
    end else if (ctl.insert && ahead) begin
      cur <= prev_ahead ? prev : ctl.ins;
    end else if (ctl.rotate) begin
      cur <= next;
    end
  end

endmodule

FILE: design/gtbs_bin_cell.sv
`timescale 1ns / 1ps
module gtbs_bin_cell import gtbs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  bin_ctl_t            ctl,
  input  logic [BIN_BITS-1:0] pos,
  input  bin_ent_t            next,
  input  logic                next_lt,
  output bin_ent_t            cur,
  output logic                lt
);

  assign lt = cur.valid && ((cur.load < ctl.key.load) ||
              ((cur.load == ctl.key.load) && (cur.bin < ctl.key.bin)));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (ctl.init) begin
      cur.valid <= ({{(CNT_BITS){1'b0}}, pos} < {{(BIN_BITS){1'b0}}, ctl.used});
      cur.load  <= '0;
      cur.bin   <= pos;
      cur.count <= '0;
    end else if (ctl.step) begin
      // head leaves, entries before the updated key move up, key drops in
      if (next_lt) begin
        cur <= next;
      end else if ((pos == '0) || lt) begin
        cur <= ctl.key;
      end
    end else if (ctl.shift) begin
      cur <= next;
    end
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import gtbs_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_TARGET = 750;
  localparam int BIG_TILES = 300;

  class schedule_board;
    logic [WORK_BITS-1:0] work_mem[MAX_TILES];
    int unsigned tile_cnt;
    logic [CFG_BITS-1:0] bin_reg;
    bit dirty;
    logic [CNT_BITS-1:0] end_mem[MAX_BINS];
    int unsigned tile_order[MAX_TILES];
    logic [SUM_BITS-1:0] prefix_mem[MAX_TILES];
    int unsigned rank_order[MAX_TILES];
    int unsigned rank_bin[MAX_TILES];
    out_word_t pending[$];
    int unsigned mismatches;

    function new();
      bin_reg = BIN_COUNT_RESET;
      tile_cnt = 0;
      dirty = 1;
      mismatches = 0;
    endfunction

    function int unsigned bins_in_use();
      if (bin_reg == 0) return 1;
      if (bin_reg > MAX_BINS) return MAX_BINS;
      return bin_reg;
    endfunction

    function bit ahead_of(int unsigned a, int unsigned b);
      if (work_mem[a] != work_mem[b]) return work_mem[a] > work_mem[b];
      return a > b;
    endfunction

    // longest work first, each tile onto the lightest bin
    function void rebuild();
      int unsigned nb, used, cum, best, j, pos;
      logic [SUM_BITS-1:0] load[MAX_BINS];
      int unsigned fill[MAX_BINS];
      logic [SUM_BITS-1:0] acc;
      nb = bins_in_use();
      used = (tile_cnt < nb) ? tile_cnt : nb;
      for (int unsigned i = 0; i < tile_cnt; i++) begin
        j = i;
        while (j > 0 && ahead_of(i, rank_order[j-1])) begin
          rank_order[j] = rank_order[j-1];
          j--;
        end
        rank_order[j] = i;
      end
      for (int k = 0; k < MAX_BINS; k++) begin
        load[k] = '0;
        fill[k] = 0;
      end
      for (int unsigned i = 0; i < tile_cnt; i++) begin
        best = 0;
        for (int unsigned k = 1; k < used; k++)
          if (load[k] < load[best]) best = k;
        rank_bin[i] = best;
        load[best] = load[best] + SUM_BITS'(work_mem[rank_order[i]]);
        fill[best]++;
      end
      cum = 0;
      for (int unsigned k = 0; k < nb; k++) begin
        pos = (k < used) ? fill[k] : 0;
        fill[k] = cum;
        cum += pos;
        end_mem[k] = CNT_BITS'(cum);
      end
      for (int unsigned i = 0; i < tile_cnt; i++) begin
        tile_order[fill[rank_bin[i]]] = rank_order[i];
        fill[rank_bin[i]]++;
      end
      acc = '0;
      for (int unsigned i = 0; i < tile_cnt; i++) begin
        acc = acc + SUM_BITS'(work_mem[i]);
        prefix_mem[i] = acc;
      end
      dirty = 0;
    endfunction

    function void write_bins(logic [CFG_BITS-1:0] v);
      bin_reg = v;
      dirty = 1;
    endfunction

    function void note_input(in_word_t w);
      out_word_t r;
      int unsigned nb, idx;
      case (w.op)
        OP_CLEAR: begin
          tile_cnt = 0;
          dirty = 1;
        end
        OP_APPEND: begin
          if (tile_cnt < MAX_TILES) begin
            work_mem[tile_cnt] = w.tile_work;
            tile_cnt++;
          end
          dirty = 1;
        end
        OP_READ: begin
          if (dirty) rebuild();
          nb = bins_in_use();
          idx = 32'(w.word_index);
          r = '0;
          if (idx < nb) r.word = SUM_BITS'(end_mem[idx]);
          else if (idx < nb + tile_cnt) r.word = SUM_BITS'(tile_order[idx - nb]);
          else if (idx < nb + 2 * tile_cnt) r.word = prefix_mem[idx - nb - tile_cnt];
          else r.out_of_range = 1'b1;
          pending = {pending, r};
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: word=%0d oor=%0b", got.word,
                                       got.out_of_range);
        return;
      end
      want = pending.pop_front();
      if (got.word !== want.word || got.out_of_range !== want.out_of_range) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word mismatch: expected word=%0d oor=%0b, got word=%0d oor=%0b",
                   want.word, want.out_of_range, got.word, got.out_of_range);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_write = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  schedule_board board = new();
  bit gaps_on = 1'b1;
  int unsigned sent = 0;
  int unsigned stall_left = 0;
  int unsigned quiet = 0;

  always #6 clk = ~clk;

  greedy_tile_bin_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // result side: checker, receiver stalls and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_result(out_word);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(logic [OP_BITS-1:0] op, logic [WORK_BITS-1:0] work,
                      logic [IDX_BITS-1:0] idx);
    in_word_t w;
    w.op = op;
    w.tile_work = work;
    w.word_index = idx;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    board.note_input(w);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bins(logic [CFG_BITS-1:0] v);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.write_bins(v);
  endtask

  function automatic logic [WORK_BITS-1:0] pick_work(int mode);
    case (mode)
      0: return WORK_BITS'($urandom_range(0, 3));
      1: return WORK_BITS'($urandom_range(0, 40));
      default: return WORK_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [IDX_BITS-1:0] pick_index();
    int unsigned span;
    span = board.bins_in_use() + 2 * board.tile_cnt;
    case ($urandom_range(0, 9))
      0: return IDX_BITS'($urandom);
      1: return IDX_BITS'(span);
      2: return IDX_BITS'(span - 1);
      default: return IDX_BITS'($urandom_range(0, span + 1));
    endcase
  endfunction

  task automatic run_task(int unsigned tiles, int mode, int unsigned reads);
    send(OP_CLEAR, WORK_BITS'($urandom), IDX_BITS'($urandom));
    repeat (tiles) send(OP_APPEND, pick_work(mode), IDX_BITS'($urandom));
    repeat (reads) begin
      // occasional noise inside the read burst
      case ($urandom_range(0, 29))
        0: send(OP_UNUSED, WORK_BITS'($urandom), IDX_BITS'($urandom));
        1: send(OP_APPEND, pick_work(mode), IDX_BITS'($urandom));
        default: send(OP_READ, WORK_BITS'($urandom), pick_index());
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty task at reset bin count, then appends, an unused op and reads
    for (int i = 0; i <= 9; i++) send(OP_READ, '0, IDX_BITS'(i));
    send(OP_READ, '0, 12'hFFF);
    send(OP_APPEND, 24'hFFFFFF, '0);
    send(OP_APPEND, 24'h000000, 12'hFFF);
    send(OP_APPEND, 24'hFFFFFF, '0);
    send(OP_UNUSED, 24'hFFFFFF, 12'hFFF);
    send(OP_APPEND, 24'h000005, '0);
    send(OP_APPEND, 24'h000005, '0);
    for (int i = 0; i < 18; i += 2) send(OP_READ, '0, IDX_BITS'(i));

    set_bins(7'd0);
    run_task(5, 0, 12);
    set_bins(7'd127);
    run_task(9, 1, 12);
    set_bins(7'd64);
    // large task with wide work values
    run_task(BIG_TILES, 2, 20);
    send(OP_READ, '0, IDX_BITS'(64 + 2 * BIG_TILES - 1));
    send(OP_READ, '0, IDX_BITS'(64 + 2 * BIG_TILES));
    set_bins(7'd1);
    run_task(12, 0, 15);

    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) set_bins(CFG_BITS'($urandom_range(1, 20)));
      if (sent > ITEM_TARGET - 100) gaps_on = 1'b0;
      run_task($urandom_range(0, 30), $urandom_range(0, 2), $urandom_range(4, 20));
    end

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
